FILE: rtl/core/dltq_pkg.sv
// package for the delta-list timer queue
// types, codes and defaults shared by every module; depends on nothing
`timescale 1ns / 1ps

package dltq_pkg;

    localparam int DEF_NUM_TIMERS = 16;
    localparam int DEF_LOAD_BITS  = 16;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_STOP  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    localparam logic [1:0] EVT_STARTED  = 2'd0;
    localparam logic [1:0] EVT_REJECTED = 2'd1;
    localparam logic [1:0] EVT_STOPPED  = 2'd2;
    localparam logic [1:0] EVT_EXPIRED  = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  timer_id;
        logic [15:0] load;
    } in_item_t;

    typedef struct packed {
        logic [3:0] event_timer;
        logic [1:0] event_code;
        logic       last_event;
    } out_item_t;

    typedef struct packed {
        logic       push;
        logic [3:0] push_id;
        logic       single;
        logic [3:0] single_id;
        logic [1:0] single_code;
        logic       drain;
    } evt_ctl_t;

    typedef struct packed {
        logic can_load;
        logic empty;
    } evt_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UL_CHK,
        S_UL_FOLD,
        S_INS_START,
        S_INS_CHK,
        S_INS_W1,
        S_INS_W2,
        S_TK_CHK,
        S_RESULT,
        S_DRAIN
    } state_t;

endpackage

FILE: rtl/core/dltq_slot_mem.sv
// per-slot delta and link memories, one registered read port, one write port each
// depends on dltq_pkg
`timescale 1ns / 1ps

module dltq_slot_mem
    import dltq_pkg::*;
#(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS,
    parameter int LOAD_BITS  = DEF_LOAD_BITS,
    localparam int IDX_W     = $clog2(NUM_TIMERS),
    localparam int LINK_W    = $clog2(NUM_TIMERS + 1)
)
(
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [LOAD_BITS-1:0] rd_delta,
    output logic [LINK_W-1:0]    rd_link,
    input  logic                 dw_en,
    input  logic [IDX_W-1:0]     dw_addr,
    input  logic [LOAD_BITS-1:0] dw_data,
    input  logic                 lw_en,
    input  logic [IDX_W-1:0]     lw_addr,
    input  logic [LINK_W-1:0]    lw_data
);

    logic [LOAD_BITS-1:0] delta_mem [NUM_TIMERS];
    logic [LINK_W-1:0]    link_mem  [NUM_TIMERS];

    always_ff @(posedge clk)
    begin
        if (dw_en)
        begin
            delta_mem[dw_addr] <= dw_data;
        end
        if (rd_en)
        begin
            rd_delta <= delta_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lw_en)
        begin
            link_mem[lw_addr] <= lw_data;
        end
        if (rd_en)
        begin
            rd_link <= link_mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/dltq_evt_queue.sv
// result register and expiry stack, drained newest first
// depends on dltq_pkg
`timescale 1ns / 1ps

module dltq_evt_queue
    import dltq_pkg::*;
#(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS,
    localparam int IDX_W     = $clog2(NUM_TIMERS),
    localparam int CNT_W     = $clog2(NUM_TIMERS + 1)
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  evt_ctl_t  ctl,
    output evt_stat_t stat,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic [3:0]       stk_mem [NUM_TIMERS];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_dec;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_item_t        out_data_reg;
    logic             can_load;
    logic             pop;

    assign can_load  = !out_valid_reg || out_ready;
    assign cnt_dec   = cnt_reg - CNT_W'(1);
    assign pop       = ctl.drain && (cnt_reg != '0) && can_load;
    assign stat      = '{can_load: can_load, empty: (cnt_reg == '0)};
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctl.push)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop)
        begin
            cnt_next = cnt_dec;
        end
        if (pop || (ctl.single && can_load))
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            stk_mem[cnt_reg[IDX_W-1:0]] <= ctl.push_id;
        end
        if (pop)
        begin
            out_data_reg <= '{event_timer: stk_mem[cnt_dec[IDX_W-1:0]],
                              event_code:  EVT_EXPIRED,
                              last_event:  (cnt_reg == CNT_W'(1))};
        end
        else if (ctl.single && can_load)
        begin
            out_data_reg <= '{event_timer: ctl.single_id,
                              event_code:  ctl.single_code,
                              last_event:  1'b1};
        end
    end

endmodule

FILE: rtl/core/delta_list_timer_queue.sv
// delta-list timer queue top: list-walk sequencer over the slot memories
// depends on dltq_pkg, dltq_slot_mem, dltq_evt_queue
// idle timer start rejected or stopped: straight to result; unlink and insert walk one slot per cycle
// one transaction at a time: in_ready is high only in idle, until the list walk is done
// tick: stacks expiring timers, then one result per cycle as the consumer takes them
// reset: all timers stopped and the list empty at once, no clearing pass
`timescale 1ns / 1ps

module delta_list_timer_queue
    import dltq_pkg::*;
#(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS,
    parameter int LOAD_BITS  = DEF_LOAD_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int IDX_W  = $clog2(NUM_TIMERS);
    localparam int LINK_W = $clog2(NUM_TIMERS + 1);
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_TIMERS);

    state_t               state_reg, state_next;
    logic [NUM_TIMERS-1:0] run_reg, run_next;
    logic [LINK_W-1:0]    head_reg, head_next;
    logic [LINK_W-1:0]    cur_reg, cur_next;
    logic [LINK_W-1:0]    prev_reg, prev_next;
    logic [IDX_W-1:0]     slot_reg, slot_next;
    logic [LOAD_BITS-1:0] load_reg, load_next;
    logic [LOAD_BITS-1:0] sum_reg, sum_next;
    logic [LOAD_BITS-1:0] dlt_reg, dlt_next;
    logic                 stop_reg, stop_next;
    logic                 first_reg, first_next;
    logic [1:0]           code_reg, code_next;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [LOAD_BITS-1:0] rd_delta;
    logic [LINK_W-1:0]    rd_link;
    logic                 dw_en;
    logic [IDX_W-1:0]     dw_addr;
    logic [LOAD_BITS-1:0] dw_data;
    logic                 lw_en;
    logic [IDX_W-1:0]     lw_addr;
    logic [LINK_W-1:0]    lw_data;

    evt_ctl_t             evt_ctl;
    evt_stat_t            evt_stat;

    logic [IDX_W-1:0]     in_slot;
    logic [LOAD_BITS-1:0] in_load;
    logic [LOAD_BITS:0]   walk_sum;
    logic [LOAD_BITS-1:0] new_delta;
    logic                 expire;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_slot   = IDX_W'(in_data.timer_id);
    assign in_load   = LOAD_BITS'(in_data.load);
    assign walk_sum  = {1'b0, sum_reg} + {1'b0, rd_delta};
    assign new_delta = load_reg - sum_reg;
    assign expire    = first_reg ? (rd_delta <= LOAD_BITS'(1)) : (rd_delta == '0);

    dltq_slot_mem #(
        .NUM_TIMERS (NUM_TIMERS),
        .LOAD_BITS  (LOAD_BITS)
    ) u_slot_mem (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_delta (rd_delta),
        .rd_link  (rd_link),
        .dw_en    (dw_en),
        .dw_addr  (dw_addr),
        .dw_data  (dw_data),
        .lw_en    (lw_en),
        .lw_addr  (lw_addr),
        .lw_data  (lw_data)
    );

    dltq_evt_queue #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_evt_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (evt_ctl),
        .stat      (evt_stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always_comb
    begin
        state_next = state_reg;
        run_next   = run_reg;
        head_next  = head_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        slot_next  = slot_reg;
        load_next  = load_reg;
        sum_next   = sum_reg;
        dlt_next   = dlt_reg;
        stop_next  = stop_reg;
        first_next = first_reg;
        code_next  = code_reg;
        rd_en      = 1'b0;
        rd_addr    = cur_reg[IDX_W-1:0];
        dw_en      = 1'b0;
        dw_addr    = cur_reg[IDX_W-1:0];
        dw_data    = rd_delta;
        lw_en      = 1'b0;
        lw_addr    = prev_reg[IDX_W-1:0];
        lw_data    = rd_link;
        evt_ctl    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.func == FUNC_TICK)
                    begin
                        if (head_reg != LINK_NULL)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg[IDX_W-1:0];
                            cur_next   = head_reg;
                            first_next = 1'b1;
                            state_next = S_TK_CHK;
                        end
                    end
                    else if ((in_data.func == FUNC_START || in_data.func == FUNC_STOP)
                             && (32'(in_data.timer_id) < NUM_TIMERS))
                    begin
                        slot_next = in_slot;
                        load_next = in_load;
                        stop_next = (in_data.func == FUNC_STOP);
                        if (run_reg[in_slot])
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg[IDX_W-1:0];
                            cur_next   = head_reg;
                            prev_next  = LINK_NULL;
                            state_next = S_UL_CHK;
                        end
                        else if (in_data.func == FUNC_STOP)
                        begin
                            code_next  = EVT_STOPPED;
                            state_next = S_RESULT;
                        end
                        else if (in_load == '0)
                        begin
                            code_next  = EVT_REJECTED;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_INS_START;
                        end
                    end
                end
            end

            S_UL_CHK:
            begin
                if (cur_reg[IDX_W-1:0] == slot_reg)
                begin
                    run_next[slot_reg] = 1'b0;
                    if (prev_reg == LINK_NULL)
                    begin
                        head_next = rd_link;
                    end
                    else
                    begin
                        lw_en = 1'b1;
                    end
                    if (rd_link != LINK_NULL)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = rd_link[IDX_W-1:0];
                        dlt_next   = rd_delta;
                        cur_next   = rd_link;
                        state_next = S_UL_FOLD;
                    end
                    else if (stop_reg)
                    begin
                        code_next  = EVT_STOPPED;
                        state_next = S_RESULT;
                    end
                    else if (load_reg == '0)
                    begin
                        code_next  = EVT_REJECTED;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_INS_START;
                    end
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = rd_link[IDX_W-1:0];
                    prev_next = cur_reg;
                    cur_next  = rd_link;
                end
            end

            S_UL_FOLD:
            begin
                dw_en   = 1'b1;
                dw_data = rd_delta + dlt_reg;
                if (stop_reg)
                begin
                    code_next  = EVT_STOPPED;
                    state_next = S_RESULT;
                end
                else if (load_reg == '0)
                begin
                    code_next  = EVT_REJECTED;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_INS_START;
                end
            end

            S_INS_START:
            begin
                sum_next  = '0;
                prev_next = LINK_NULL;
                cur_next  = head_reg;
                if (head_reg == LINK_NULL)
                begin
                    state_next = S_INS_W1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg[IDX_W-1:0];
                    state_next = S_INS_CHK;
                end
            end

            S_INS_CHK:
            begin
                if (walk_sum >= {1'b0, load_reg})
                begin
                    dlt_next   = rd_delta;
                    state_next = S_INS_W1;
                end
                else
                begin
                    sum_next  = walk_sum[LOAD_BITS-1:0];
                    prev_next = cur_reg;
                    cur_next  = rd_link;
                    if (rd_link == LINK_NULL)
                    begin
                        state_next = S_INS_W1;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = rd_link[IDX_W-1:0];
                    end
                end
            end

            S_INS_W1:
            begin
                dw_en              = 1'b1;
                dw_addr            = slot_reg;
                dw_data            = new_delta;
                lw_en              = 1'b1;
                lw_addr            = slot_reg;
                lw_data            = cur_reg;
                run_next[slot_reg] = 1'b1;
                if (prev_reg == LINK_NULL)
                begin
                    head_next = LINK_W'(slot_reg);
                end
                state_next = S_INS_W2;
            end

            S_INS_W2:
            begin
                lw_en      = (prev_reg != LINK_NULL);
                lw_data    = LINK_W'(slot_reg);
                dw_en      = (cur_reg != LINK_NULL);
                dw_data    = dlt_reg - new_delta;
                code_next  = EVT_STARTED;
                state_next = S_RESULT;
            end

            S_TK_CHK:
            begin
                if (expire)
                begin
                    evt_ctl.push                    = 1'b1;
                    evt_ctl.push_id                 = 4'(cur_reg[IDX_W-1:0]);
                    run_next[cur_reg[IDX_W-1:0]]    = 1'b0;
                    first_next                      = 1'b0;
                    cur_next                        = rd_link;
                    if (rd_link == LINK_NULL)
                    begin
                        head_next  = LINK_NULL;
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = rd_link[IDX_W-1:0];
                    end
                end
                else if (first_reg)
                begin
                    dw_en      = 1'b1;
                    dw_data    = rd_delta - LOAD_BITS'(1);
                    state_next = S_IDLE;
                end
                else
                begin
                    head_next  = cur_reg;
                    state_next = S_DRAIN;
                end
            end

            S_RESULT:
            begin
                if (evt_stat.can_load)
                begin
                    evt_ctl.single      = 1'b1;
                    evt_ctl.single_id   = 4'(slot_reg);
                    evt_ctl.single_code = code_reg;
                    state_next          = S_IDLE;
                end
            end

            S_DRAIN:
            begin
                evt_ctl.drain = 1'b1;
                if (evt_stat.empty)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            run_reg   <= '0;
            head_reg  <= LINK_NULL;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        slot_reg  <= slot_next;
        load_reg  <= load_next;
        sum_reg   <= sum_next;
        dlt_reg   <= dlt_next;
        stop_reg  <= stop_next;
        first_reg <= first_next;
        code_reg  <= code_next;
    end

    // expiry stack is always drained before the next transaction
    a_idle_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> evt_stat.empty)
        else $error("expiry stack not empty in idle");

    // an empty list leaves no timer marked running
    a_empty_list_none_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && head_reg == LINK_NULL) |-> (run_reg == '0))
        else $error("running timer with empty list");

    // only expiries come in groups
    a_nonlast_is_expiry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.last_event) |-> (out_data.event_code == EVT_EXPIRED))
        else $error("non-final result that is not an expiry");

endmodule
